[sv/weighted_sum_on_change_assert.svh]
// Assertion macros used by the top RTL file of the weighted sum block.
`ifndef WEIGHTED_SUM_ON_CHANGE_ASSERT_SVH
`define WEIGHTED_SUM_ON_CHANGE_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define WSOC_ASSERT_IMPL(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("weighted_sum_on_change: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define WSOC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("weighted_sum_on_change: next-cycle check failed");

`endif

[sv/wsoc_pkg.sv]
`timescale 1ns / 1ps

package wsoc_pkg;

  localparam int PORT_SLOTS   = 4;
  localparam int PORT_IDX_W   = 2;
  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 16;
  localparam int SUM_W        = 34;
  localparam int DIGIT_W      = 4;
  localparam int NUM_DIGITS   = SAMPLE_W / DIGIT_W;
  localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS);
  localparam int REG_IDX_W    = 3;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [PORT_SLOTS-1:0]      port_mask_t;

  localparam weight_t    WEIGHT_RESET = 16'sd4096;
  localparam port_mask_t MASK_RESET   = 4'hF;

  // Register indexes, byte address 4*index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WEIGHT_0   = 3'd0,
    REG_WEIGHT_1   = 3'd1,
    REG_WEIGHT_2   = 3'd2,
    REG_WEIGHT_3   = 3'd3,
    REG_CONN_MASK  = 3'd4,
    REG_HAS_OUTPUT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic       start;
    port_mask_t mask;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

[sv/wsoc_mac.sv]
`timescale 1ns / 1ps

// Digit-serial multiply-accumulate over the live ports: one 4-bit digit of
// one sample per cycle times that port's weight, four digits per port.
module wsoc_mac #(
  parameter int LIVE_PORTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wsoc_pkg::mac_ctrl_t ctrl_i,
  input  wsoc_pkg::weight_t   weights_i [wsoc_pkg::PORT_SLOTS],
  input  wsoc_pkg::sample_t   samples_i [wsoc_pkg::PORT_SLOTS],
  output wsoc_pkg::mac_stat_t stat_o,
  output wsoc_pkg::sum_t      sum_o
);
  import wsoc_pkg::*;

  localparam logic [PORT_IDX_W-1:0]  LAST_PORT  = PORT_IDX_W'(LIVE_PORTS - 1);
  localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(NUM_DIGITS - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [PORT_IDX_W-1:0]         port_r;
  logic [DIGIT_CNT_W-1:0]        digit_r;
  logic [SAMPLE_W-1:0]           shift_r;
  sum_t                          acc_r;

  logic [DIGIT_W-1:0]            digit;
  logic signed [DIGIT_W:0]       digit_s;
  weight_t                       weight_sel;
  logic signed [WEIGHT_W+DIGIT_W:0] prod;
  sum_t                          prod_ext;
  sum_t                          acc_nxt;
  logic [SAMPLE_W-1:0]           shift_nxt;
  logic [PORT_IDX_W-1:0]         port_next;

  // Form one partial product; the top digit carries the sample's sign
  always_comb begin
    digit      = shift_r[DIGIT_W-1:0];
    digit_s    = (digit_r == LAST_DIGIT) ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
    weight_sel = ctrl_i.mask[port_r] ? weights_i[port_r] : '0;
    prod       = weight_sel * digit_s;
    prod_ext   = SUM_W'(prod);
    acc_nxt    = acc_r + (prod_ext <<< (DIGIT_W * digit_r));
    shift_nxt  = {DIGIT_W'(0), shift_r[SAMPLE_W-1:DIGIT_W]};
    port_next  = port_r + 1'b1;
  end

  // Step through digits, then ports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl_i.start) begin
        busy_r  <= 1'b1;
        port_r  <= '0;
        digit_r <= '0;
        acc_r   <= '0;
        shift_r <= samples_i[0];
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        if (digit_r == LAST_DIGIT) begin
          digit_r <= '0;
          if (port_r == LAST_PORT) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            port_r  <= port_next;
            shift_r <= samples_i[port_next];
          end
        end else begin
          digit_r <= digit_r + 1'b1;
          shift_r <= shift_nxt;
        end
      end
    end
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign sum_o       = acc_r;

endmodule

[sv/weighted_sum_on_change.sv]
`timescale 1ns / 1ps
// Weighted sum of up to four sample ports, emitted when it changes.
// Input stream: each beat carries one signed 16-bit sample (in_tdata) for the
// port in in_tuser. A beat on a port outside connected_mask is dropped.
// Once every connected port has delivered a sample, each further sample
// triggers a new weighted sum (Q2.14 weights, 34-bit exact result, 14
// fraction bits); the first sum is always sent, later ones only if they
// differ from the previous sum. has_output = 0 keeps the state going but
// sends no beats.
// Handshake: with P = min(NUM_PORTS, 4) live ports, one digit-serial
// multiplier works through all P ports, digit by digit, so a beat that needs
// a sum holds in_tready low until its result is loaded into the output
// register or found not to need sending. A beat that needs no sum does not.
// The result sits in an output register; while the receiver stalls, a new
// beat is still taken and worked on, and only its own result waits for the
// register to free up.
// Reset (synchronous, rst_n low) restores weights to 0.25, all ports
// connected, output on, and forgets all samples. Registers sit on the APB
// port at 4*index; write them only while the block is idle.
`include "weighted_sum_on_change_assert.svh"

module weighted_sum_on_change #(
  parameter int NUM_PORTS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wsoc_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] sample_value
  input  logic [wsoc_pkg::PORT_IDX_W-1:0]      in_tuser,   // [1:0] port_index
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wsoc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [33:0] sum_value
  // Configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [wsoc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [wsoc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [wsoc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import wsoc_pkg::*;

  localparam int         LIVE_PORTS = (NUM_PORTS < PORT_SLOTS) ? NUM_PORTS : PORT_SLOTS;
  localparam port_mask_t LIVE_BITS  = port_mask_t'((1 << LIVE_PORTS) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_t;

  // Configuration registers
  weight_t    weight_r [PORT_SLOTS];
  port_mask_t conn_mask_r;
  logic       has_output_r;
  logic       cfg_wr;

  // Sample store and control
  sample_t    samples_r [LIVE_PORTS];
  sample_t    samples_w [PORT_SLOTS];
  state_t     state_r, state_nxt;
  logic       start_r, start_nxt;
  port_mask_t seen_r, seen_nxt;
  logic       started_r, started_nxt;
  sum_t       last_sum_r, last_sum_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  sum_t       out_data_r, out_data_nxt;

  port_mask_t live_mask;
  port_mask_t seen_upd;
  logic       in_acc;
  logic       in_hit;
  logic       need_sum;
  logic       emit_want;
  mac_ctrl_t  mac_ctrl;
  mac_stat_t  mac_stat;
  sum_t       mac_sum;

  // Write registers on the access beat
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        weight_r[i] <= WEIGHT_RESET;
      end
      conn_mask_r  <= MASK_RESET;
      has_output_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_WEIGHT_0:   weight_r[0]  <= cfg_pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_1:   weight_r[1]  <= cfg_pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_2:   weight_r[2]  <= cfg_pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_3:   weight_r[3]  <= cfg_pwdata[WEIGHT_W-1:0];
        REG_CONN_MASK:  conn_mask_r  <= cfg_pwdata[PORT_SLOTS-1:0];
        REG_HAS_OUTPUT: has_output_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_WEIGHT_0:   cfg_prdata = CFG_DATA_W'($unsigned(weight_r[0]));
      REG_WEIGHT_1:   cfg_prdata = CFG_DATA_W'($unsigned(weight_r[1]));
      REG_WEIGHT_2:   cfg_prdata = CFG_DATA_W'($unsigned(weight_r[2]));
      REG_WEIGHT_3:   cfg_prdata = CFG_DATA_W'($unsigned(weight_r[3]));
      REG_CONN_MASK:  cfg_prdata = CFG_DATA_W'(conn_mask_r);
      REG_HAS_OUTPUT: cfg_prdata = CFG_DATA_W'(has_output_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Decode the incoming beat
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign live_mask = conn_mask_r & LIVE_BITS;
  assign in_hit    = live_mask[in_tuser];
  assign seen_upd  = seen_r | (port_mask_t'(1) << in_tuser);
  assign need_sum  = started_r || ((seen_upd & live_mask) == live_mask);

  // Store samples of live ports; unused slots read as zero
  for (genvar p = 0; p < PORT_SLOTS; p++) begin : g_slot
    if (p < LIVE_PORTS) begin : g_live
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          samples_r[p] <= '0;
        end else if (in_acc && in_hit && (in_tuser == PORT_IDX_W'(p))) begin
          samples_r[p] <= in_tdata[SAMPLE_W-1:0];
        end
      end
      assign samples_w[p] = samples_r[p];
    end else begin : g_dead
      assign samples_w[p] = '0;
    end
  end

  // Serial multiply-accumulate
  assign mac_ctrl.start = start_r;
  assign mac_ctrl.mask  = live_mask;

  wsoc_mac #(
    .LIVE_PORTS (LIVE_PORTS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_i    (mac_ctrl),
    .weights_i (weight_r),
    .samples_i (samples_w),
    .stat_o    (mac_stat),
    .sum_o     (mac_sum)
  );

  // Sequence one beat: store, sum, compare, send
  assign emit_want = (!started_r || (mac_sum != last_sum_r)) && has_output_r;

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = 1'b0;
    seen_nxt       = seen_r;
    started_nxt    = started_r;
    last_sum_nxt   = last_sum_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_hit) begin
          seen_nxt = seen_upd;
          if (need_sum) begin
            start_nxt = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (mac_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_want || !out_tvalid_r || out_tready) begin
          last_sum_nxt = mac_sum;
          started_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
          if (emit_want) begin
            out_tvalid_nxt = 1'b1;
            out_data_nxt   = mac_sum;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_r      <= 1'b0;
      seen_r       <= '0;
      started_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      seen_r       <= seen_nxt;
      started_r    <= started_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      last_sum_r   <= last_sum_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_W - SUM_W)'(0), out_data_r};

  // Checks
  `WSOC_ASSERT_IMPL(a_done_in_mac, clk, rst_n, mac_stat.done, state_r == ST_MAC)
  `WSOC_ASSERT_NEXT(a_start_busy, clk, rst_n, start_r, mac_stat.busy)
  `WSOC_ASSERT_IMPL(a_load_from_emit, clk, rst_n, $rose(out_tvalid_r), $past(state_r == ST_EMIT))
  `WSOC_ASSERT_NEXT(a_miss_idle, clk, rst_n, in_acc && !in_hit, state_r == ST_IDLE)

endmodule
